/* rtl/buddy_block_allocator_top_macros.svh */
// assertion macros used by the allocator checker
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define BBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// next-cycle implication, reset masks the check
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

/* rtl/bba_pkg.sv */
// types, constants and state codes of the buddy block allocator
package bba_pkg;

	localparam int MAX_ORDER       = 10;
	localparam int MIN_BLOCK_BYTES = 32;
	localparam int HEADER_BYTES    = 4;

	localparam int NUNITS = 1 << MAX_ORDER;
	localparam int IDX_W  = 10;
	localparam int ORD_W  = 4;
	localparam int LINK_W = IDX_W + 1;
	localparam int NLISTS = MAX_ORDER + 1;

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUNITS);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_BLOCK = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic             command;
		logic [15:0]      request_bytes;
		logic [IDX_W-1:0] free_index;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] granted_index;
		logic [ORD_W-1:0] granted_order;
	} rsp_t;

	typedef struct packed {
		logic             free;
		logic [ORD_W-1:0] order;
	} unit_t;

	typedef struct packed {
		logic [LINK_W-1:0] next;
		logic [LINK_W-1:0] prev;
	} link_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_RD,
		S_A_SPLIT,
		S_A_APP,
		S_A_NEXTW,
		S_F_CHK,
		S_F_LOOP,
		S_F_BUD,
		S_F_UNL,
		S_F_PW,
		S_F_N,
		S_F_NW,
		S_F_MRG,
		S_F_FIN,
		S_F_TW,
		S_DONE
	} state_t;

endpackage

/* rtl/bba_ram.sv */
// generic single-write, single-read ram with registered read data
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/buddy_block_allocator_top.sv */
// buddy block allocator: command decode, list walk sequencer and state memories
// a rejected allocate or out-of-range free goes straight to the result; an allocate
//   reads its list head, unlinks it, then does one split append per level; a free checks
//   the index, then per level does one buddy check, unlink and merge
// throughput: one request at a time, the next is taken the cycle after the result loads
// reset and every region_order write start a clearing pass over all NUNITS (1024) entries of
//   the unit and link rams, no request is taken meanwhile; lists reset to one free top block
module buddy_block_allocator_top
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// control state
	state_t            state_q, state_d;
	logic [ORD_W-1:0]  reg_q;          // saturated region order
	logic [IDX_W:0]    clr_q;          // clearing pass address
	logic              rsp_valid_q;
	logic [LINK_W-1:0] head_q [NLISTS];
	logic [LINK_W-1:0] tail_q [NLISTS];

	// working registers of the current request
	logic              cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  b_q;
	logic [ORD_W-1:0]  lvl_q;
	logic [ORD_W-1:0]  kord_q;
	logic [ORD_W-1:0]  stored_q;
	logic [LINK_W-1:0] p_q, n_q, t_q;
	rsp_t              res_q;
	rsp_t              rsp_q;

	// memory ports
	logic              u_we;
	logic [IDX_W-1:0]  u_waddr, u_raddr;
	unit_t             u_wdata, u_rd;
	logic              l_we;
	logic [IDX_W-1:0]  l_waddr, l_raddr;
	link_t             l_wdata, l_rd;

	// configuration write decode
	logic             cfg_we;
	logic [ORD_W-1:0] cfg_ord;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign cfg_ord = (pwdata[ORD_W-1:0] > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
		: pwdata[ORD_W-1:0];
	assign prdata = (paddr[2] == 1'b0) ? {{(32-ORD_W){1'b0}}, reg_q} : 32'd0;

	// list head and tail at the level being worked on
	logic [LINK_W-1:0] cur_head, cur_tail;
	assign cur_head = head_q[lvl_q];
	assign cur_tail = tail_q[lvl_q];

	// smallest fitting order and lowest non-empty list at or above it
	logic [16:0]       need;
	logic [ORD_W-1:0]  k_need;
	logic [ORD_W-1:0]  i_sel;
	logic              avail_any;
	logic [NLISTS-1:0] avail;

	assign need = {1'b0, req.request_bytes} + 17'(HEADER_BYTES);

	always_comb begin
		k_need = ORD_W'(MAX_ORDER + 1);
		for (int j = MAX_ORDER; j >= 0; j--) begin
			if ((32'(MIN_BLOCK_BYTES) << j) >= 32'(need)) begin
				k_need = ORD_W'(j);
			end
		end
		for (int j = 0; j < NLISTS; j++) begin
			avail[j] = !head_q[j][LINK_W-1] && (ORD_W'(j) >= k_need)
				&& (ORD_W'(j) <= reg_q);
		end
		i_sel = '0;
		for (int j = MAX_ORDER; j >= 0; j--) begin
			if (avail[j]) begin
				i_sel = ORD_W'(j);
			end
		end
		avail_any = |avail;
	end

	// free request outside the managed region
	logic out_of_range;
	assign out_of_range = {1'b0, req.free_index} >= ((IDX_W+1)'(1) << reg_q);

	// buddies: split half at this level, merge partner at this level
	logic [IDX_W-1:0] b_lvl;
	assign b_lvl = idx_q ^ (IDX_W'(1) << lvl_q);

	// walk conditions
	logic split_more, merge_ok, rsp_load, merge_low;
	assign split_more = lvl_q > kord_q;
	assign merge_ok   = u_rd.free && (u_rd.order == lvl_q);
	assign rsp_load   = !rsp_valid_q || !rsp_stall;
	assign merge_low  = b_q < idx_q;

	// next state; an allocate unlinks its list head through the same states as a merge
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:   if (clr_q == (IDX_W+1)'(NUNITS - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (req_valid) begin
					if (req.command == CMD_ALLOC) begin
						state_d = avail_any ? S_A_RD : S_DONE;
					end else begin
						state_d = out_of_range ? S_DONE : S_F_CHK;
					end
				end
			end
			S_A_RD:    state_d = S_F_UNL;
			S_A_SPLIT: state_d = split_more ? S_A_APP : S_DONE;
			S_A_APP:   state_d = cur_tail[LINK_W-1] ? S_A_SPLIT : S_A_NEXTW;
			S_A_NEXTW: state_d = S_A_SPLIT;
			S_F_CHK:   state_d = u_rd.free ? S_DONE : S_F_LOOP;
			S_F_LOOP:  state_d = (lvl_q < reg_q) ? S_F_BUD : S_F_FIN;
			S_F_BUD:   state_d = merge_ok ? S_F_UNL : S_F_FIN;
			S_F_UNL:   state_d = l_rd.prev[LINK_W-1] ? S_F_N : S_F_PW;
			S_F_PW:    state_d = S_F_N;
			S_F_N:     state_d = n_q[LINK_W-1] ? S_F_MRG : S_F_NW;
			S_F_NW:    state_d = S_F_MRG;
			S_F_MRG:   state_d = (cmd_q == CMD_ALLOC) ? S_A_SPLIT : S_F_LOOP;
			S_F_FIN:   state_d = cur_tail[LINK_W-1] ? S_DONE : S_F_TW;
			S_F_TW:    state_d = S_DONE;
			S_DONE:    if (rsp_load) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
		// a region write restarts from one free top block
		if (cfg_we) state_d = S_CLEAR;
	end

	// memory control
	always_comb begin
		u_we    = 1'b0;
		u_waddr = idx_q;
		u_wdata = '0;
		u_raddr = b_lvl;
		l_we    = 1'b0;
		l_waddr = idx_q;
		l_wdata = '0;
		l_raddr = b_q;
		unique case (state_q)
			S_CLEAR: begin
				u_we    = 1'b1;
				u_waddr = clr_q[IDX_W-1:0];
				u_wdata = (clr_q == '0) ? unit_t'{free: 1'b1, order: reg_q} : '0;
				l_we    = 1'b1;
				l_waddr = clr_q[IDX_W-1:0];
				l_wdata = link_t'{next: NIL_LINK, prev: NIL_LINK};
			end
			S_IDLE:  u_raddr = req.free_index;
			S_A_RD:  l_raddr = cur_head[IDX_W-1:0];
			S_A_SPLIT: begin
				if (!split_more) begin
					u_we    = 1'b1;
					u_wdata = unit_t'{free: 1'b0, order: kord_q};
				end
			end
			S_A_APP: begin
				// upper half goes to the tail of its list
				u_we    = 1'b1;
				u_waddr = b_lvl;
				u_wdata = unit_t'{free: 1'b1, order: lvl_q};
				l_we    = 1'b1;
				l_waddr = b_lvl;
				l_wdata = link_t'{next: NIL_LINK, prev: cur_tail};
				l_raddr = cur_tail[IDX_W-1:0];
			end
			S_A_NEXTW: begin
				// a tail equal to the appended entry was rewritten in the append cycle
				l_we    = 1'b1;
				l_waddr = t_q[IDX_W-1:0];
				l_wdata = link_t'{next: {1'b0, b_q},
					prev: (t_q == {1'b0, b_q}) ? t_q : l_rd.prev};
			end
			S_F_CHK:  u_raddr = b_lvl;
			S_F_LOOP: u_raddr = b_lvl;
			S_F_BUD:  l_raddr = b_q;
			S_F_UNL:  l_raddr = l_rd.prev[IDX_W-1:0];
			S_F_PW: begin
				l_we    = 1'b1;
				l_waddr = p_q[IDX_W-1:0];
				l_wdata = link_t'{next: n_q, prev: l_rd.prev};
			end
			S_F_N:    l_raddr = n_q[IDX_W-1:0];
			S_F_NW: begin
				l_we    = 1'b1;
				l_waddr = n_q[IDX_W-1:0];
				l_wdata = link_t'{next: l_rd.next, prev: p_q};
			end
			S_F_MRG: begin
				// unlinked entry drops its links
				l_we    = 1'b1;
				l_waddr = b_q;
				l_wdata = link_t'{next: NIL_LINK, prev: NIL_LINK};
				// absorbed entry is no longer a free block start
				if (cmd_q == CMD_FREE) begin
					u_we = 1'b1;
					if (merge_low) begin
						u_waddr = idx_q;
						u_wdata = unit_t'{free: 1'b0, order: stored_q};
					end else begin
						u_waddr = b_q;
						u_wdata = unit_t'{free: 1'b0, order: lvl_q};
					end
				end
			end
			S_F_FIN: begin
				u_we    = 1'b1;
				u_wdata = unit_t'{free: 1'b1, order: lvl_q};
				l_we    = 1'b1;
				l_wdata = link_t'{next: NIL_LINK, prev: cur_tail};
				l_raddr = cur_tail[IDX_W-1:0];
			end
			S_F_TW: begin
				l_we    = 1'b1;
				l_waddr = t_q[IDX_W-1:0];
				l_wdata = link_t'{next: {1'b0, idx_q},
					prev: (t_q == {1'b0, idx_q}) ? t_q : l_rd.prev};
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			reg_q       <= ORD_W'(MAX_ORDER);
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			for (int j = 0; j < NLISTS; j++) begin
				head_q[j] <= (j == MAX_ORDER) ? '0 : NIL_LINK;
				tail_q[j] <= (j == MAX_ORDER) ? '0 : NIL_LINK;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			case (state_q)
				S_A_APP: begin
					if (cur_tail[LINK_W-1]) head_q[lvl_q] <= {1'b0, b_lvl};
					tail_q[lvl_q] <= {1'b0, b_lvl};
				end
				S_F_UNL: begin
					if (l_rd.prev[LINK_W-1] && cur_head == {1'b0, b_q}) begin
						head_q[lvl_q] <= l_rd.next;
					end
				end
				S_F_N: begin
					if (n_q[LINK_W-1] && cur_tail == {1'b0, b_q}) begin
						tail_q[lvl_q] <= p_q;
					end
				end
				S_F_FIN: begin
					if (cur_tail[LINK_W-1]) head_q[lvl_q] <= {1'b0, idx_q};
					tail_q[lvl_q] <= {1'b0, idx_q};
				end
				default: begin
				end
			endcase
			if (cfg_we) begin
				reg_q <= cfg_ord;
				clr_q <= '0;
				for (int j = 0; j < NLISTS; j++) begin
					head_q[j] <= (ORD_W'(j) == cfg_ord) ? '0 : NIL_LINK;
					tail_q[j] <= (ORD_W'(j) == cfg_ord) ? '0 : NIL_LINK;
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q  <= req.command;
				idx_q  <= req.free_index;
				lvl_q  <= i_sel;
				kord_q <= k_need;
				res_q  <= rsp_t'{
					status: (req.command == CMD_ALLOC) ? ST_NO_BLOCK : ST_BAD_FREE,
					granted_index: '0, granted_order: '0};
			end
			S_A_RD: begin
				// list head is the entry to unlink
				idx_q <= cur_head[IDX_W-1:0];
				b_q   <= cur_head[IDX_W-1:0];
			end
			S_A_SPLIT: begin
				if (split_more) begin
					lvl_q <= lvl_q - 1'b1;
				end else begin
					res_q <= rsp_t'{status: ST_OK, granted_index: idx_q,
						granted_order: kord_q};
				end
			end
			S_A_APP: begin
				t_q <= cur_tail;
				b_q <= b_lvl;
			end
			S_F_CHK: begin
				// clamp a stored order beyond the region
				stored_q <= u_rd.order;
				lvl_q    <= (u_rd.order > reg_q) ? reg_q : u_rd.order;
			end
			S_F_LOOP: b_q <= b_lvl;
			S_F_UNL: begin
				p_q <= l_rd.prev;
				n_q <= l_rd.next;
			end
			S_F_MRG: begin
				if (cmd_q == CMD_FREE) begin
					if (merge_low) begin
						idx_q    <= b_q;
						stored_q <= lvl_q;
					end
					lvl_q <= lvl_q + 1'b1;
				end
			end
			S_F_FIN: begin
				t_q   <= cur_tail;
				res_q <= rsp_t'{status: ST_OK, granted_index: '0, granted_order: '0};
			end
			S_DONE:  if (rsp_load) rsp_q <= res_q;
			default: begin
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// free flag and order per minimum block
	bba_ram #(
		.WIDTH($bits(unit_t)),
		.DEPTH(NUNITS)
	) u_unit_ram (
		.clk  (clk),
		.we   (u_we),
		.waddr(u_waddr),
		.wdata(u_wdata),
		.raddr(u_raddr),
		.rdata(u_rd)
	);

	// free list links per minimum block
	bba_ram #(
		.WIDTH($bits(link_t)),
		.DEPTH(NUNITS)
	) u_link_ram (
		.clk  (clk),
		.we   (l_we),
		.waddr(l_waddr),
		.wdata(l_wdata),
		.raddr(l_raddr),
		.rdata(l_rd)
	);

endmodule

/* rtl/bba_checker.sv */
// port-level checker of the allocator result channel and its bind
`include "buddy_block_allocator_top_macros.svh"

module bba_checker
	import bba_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	`BBA_ASSERT_IMPL(a_status_code, clk, arst_n, rsp_valid, rsp.status != 2'd3)
	`BBA_ASSERT_IMPL(a_fail_zero, clk, arst_n, rsp_valid && (rsp.status != ST_OK), (rsp.granted_index == '0) && (rsp.granted_order == '0))
	`BBA_ASSERT_IMPL(a_order_range, clk, arst_n, rsp_valid, rsp.granted_order <= ORD_W'(MAX_ORDER))
	`BBA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

/* sim/testbench.sv */
// self-checking testbench for the buddy block allocator top level
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bba_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 120;   // above the longest free merge walk
	localparam int LONG_HOLD      = 400;

	// block ports
	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	localparam logic [2:0] ADDR_REGION_ORDER = 3'd0;

	// one expected result, tagged with the command that caused it
	typedef struct {
		rsp_t r;
		logic cmd;
	} grant_exp_t;

	req_t       pending_reqs[$];
	grant_exp_t expected_grants[$];
	int         live_blocks[$];   // indices handed out and not yet freed by the stimulus

	int fails;
	int send_idle_pct;
	int stall_pct;
	int accepts;
	int long_hold_toggle;
	int quiet_cycles;

	// allocator shadow state
	int             region_ord;
	bit             blk_free[NUNITS];
	logic [3:0]     blk_order[NUNITS];
	int             link_next[NUNITS];
	int             link_prev[NUNITS];
	int             free_head[NLISTS];
	int             free_tail[NLISTS];

	buddy_block_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit is_blk(int x);
		return x < NUNITS;
	endfunction

	// append a block at the tail of its free list
	function automatic void list_push(int ord, int idx);
		int t;
		t = free_tail[ord];
		link_prev[idx] = is_blk(t) ? t : NUNITS;
		link_next[idx] = NUNITS;
		if (is_blk(t)) begin
			link_next[t] = idx;
		end else begin
			free_head[ord] = idx;
		end
		free_tail[ord] = idx;
	endfunction

	function automatic void list_remove(int ord, int idx);
		int p;
		int n;
		p = link_prev[idx];
		n = link_next[idx];
		if (is_blk(p)) begin
			link_next[p] = is_blk(n) ? n : NUNITS;
		end else if (free_head[ord] == idx) begin
			free_head[ord] = is_blk(n) ? n : NUNITS;
		end
		if (is_blk(n)) begin
			link_prev[n] = is_blk(p) ? p : NUNITS;
		end else if (free_tail[ord] == idx) begin
			free_tail[ord] = is_blk(p) ? p : NUNITS;
		end
		link_prev[idx] = NUNITS;
		link_next[idx] = NUNITS;
	endfunction

	// back to one free top block; orders above MAX_ORDER saturate
	function automatic void region_reset(int ord);
		region_ord = (ord > MAX_ORDER) ? MAX_ORDER : ord;
		for (int i = 0; i < NUNITS; i++) begin
			blk_free[i] = 1'b0;
			blk_order[i] = '0;
			link_next[i] = NUNITS;
			link_prev[i] = NUNITS;
		end
		for (int i = 0; i < NLISTS; i++) begin
			free_head[i] = NUNITS;
			free_tail[i] = NUNITS;
		end
		blk_free[0] = 1'b1;
		blk_order[0] = region_ord[3:0];
		list_push(region_ord, 0);
	endfunction

	// computes the grant for one request and updates the shadow lists
	function automatic rsp_t grant_for(req_t r);
		rsp_t g;
		int   need;
		int   k;
		int   i;
		int   idx;
		int   b;
		int   ord;
		g = '0;
		g.status = ST_OK;
		if (r.command == CMD_ALLOC) begin
			need = int'(r.request_bytes) + HEADER_BYTES;
			k = 0;
			while (k <= MAX_ORDER && (MIN_BLOCK_BYTES << k) < need) k++;
			idx = NUNITS;
			i = k;
			while (i <= region_ord) begin
				if (is_blk(free_head[i])) begin
					idx = free_head[i];
					break;
				end
				i++;
			end
			if (!is_blk(idx)) begin
				g.status = ST_NO_BLOCK;
			end else begin
				list_remove(i, idx);
				// split down, upper halves go back on their lists
				while (i > k) begin
					i--;
					b = (idx ^ (1 << i)) & (NUNITS - 1);
					blk_free[b] = 1'b1;
					blk_order[b] = i[3:0];
					list_push(i, b);
				end
				blk_free[idx] = 1'b0;
				blk_order[idx] = k[3:0];
				g.granted_index = idx[IDX_W-1:0];
				g.granted_order = k[3:0];
			end
		end else begin
			idx = int'(r.free_index);
			if (idx >= (1 << region_ord) || blk_free[idx]) begin
				g.status = ST_BAD_FREE;
			end else begin
				ord = int'(blk_order[idx]);
				if (ord > region_ord) ord = region_ord;
				// merge while the buddy is free at the same order
				while (ord < region_ord) begin
					b = (idx ^ (1 << ord)) & (NUNITS - 1);
					if (!blk_free[b] || int'(blk_order[b]) != ord) break;
					list_remove(ord, b);
					if (b < idx) begin
						blk_free[idx] = 1'b0;
						idx = b;
					end else begin
						blk_free[b] = 1'b0;
					end
					ord++;
				end
				blk_free[idx] = 1'b1;
				blk_order[idx] = ord[3:0];
				list_push(ord, idx);
			end
		end
		return g;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	// request side: acceptance and prediction at the rising edge
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			grant_exp_t e;
			e.r = grant_for(req);
			e.cmd = req.command;
			expected_grants.push_back(e);
			accepts++;
		end
	end

	// request driver: new request or idle at the falling edge, held while stalled
	always @(negedge clk) begin
		static int seen = 0;
		if (arst_n && (!req_valid || accepts != seen)) begin
			seen = accepts;
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result stall: random, or a long hold counted here when asked for
	always @(negedge clk) begin
		static int hold_left = 0;
		static int last_toggle = 0;
		if (long_hold_toggle != last_toggle) begin
			last_toggle = long_hold_toggle;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result monitor: compare with the oldest expected grant
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_grants.size() == 0) begin
				report("unexpected result, status", rsp.status, -1);
			end else begin
				grant_exp_t e;
				e = expected_grants.pop_front();
				if (rsp.status !== e.r.status)
					report("status", rsp.status, e.r.status);
				if (rsp.granted_index !== e.r.granted_index)
					report("granted_index", rsp.granted_index, e.r.granted_index);
				if (rsp.granted_order !== e.r.granted_order)
					report("granted_order", rsp.granted_order, e.r.granted_order);
				// successful grants become candidates for later frees
				if (e.cmd == CMD_ALLOC && e.r.status == ST_OK)
					live_blocks.push_back(int'(e.r.granted_index));
			end
		end
	end

	// watchdog: cycles in which nothing moves on any port
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("buddy_block_allocator_top verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_grants.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_region(int ord);
		drain();
		cfg_write(ADDR_REGION_ORDER, ord);
		region_reset(ord);
		live_blocks.delete();
	endtask

	task automatic push_alloc(int bytes);
		req_t r;
		r = '0;
		r.command = CMD_ALLOC;
		r.request_bytes = bytes[15:0];
		r.free_index = $urandom_range(1023);
		pending_reqs.push_back(r);
	endtask

	task automatic push_free(int idx);
		req_t r;
		r = '0;
		r.command = CMD_FREE;
		r.request_bytes = $urandom_range(16'hffff);
		r.free_index = idx[IDX_W-1:0];
		pending_reqs.push_back(r);
	endtask

	// mostly allocs with small sizes and frees of live blocks, some noise
	task automatic push_random(int n);
		int sel;
		int pick;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 45) begin
				pick = $urandom_range(99);
				if (pick < 60) push_alloc($urandom_range(200));
				else if (pick < 85) push_alloc($urandom_range(3000));
				else push_alloc($urandom_range(16'hffff));
			end else if (live_blocks.size() > 0 && sel < 90) begin
				pick = $urandom_range(live_blocks.size() - 1);
				push_free(live_blocks[pick]);
				live_blocks.delete(pick);
			end else begin
				push_free($urandom_range(1023));
			end
		end
	endtask

	initial begin
		int regions[6] = '{10, 0, 3, 15, 6, 10};
		int send_modes[4] = '{0, 83, 0, 36};
		int stall_modes[4] = '{0, 0, 83, 36};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fails = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		accepts = 0;
		long_hold_toggle = 0;
		quiet_cycles = 0;
		region_reset(10);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: size boundaries, oversize, double free, stray index
		push_alloc(0);
		push_alloc(28);           // exactly one minimum block with header
		push_alloc(29);           // one byte over, next order
		push_alloc(1020);
		push_alloc(32764);        // whole region
		push_alloc(16'hffff);     // too large for any region
		push_free(0);
		push_free(0);             // double free
		push_free(1);             // block granted to the 28-byte request
		push_free(32);
		push_alloc(32764);
		push_free(0);
		push_free(1023);
		drain();

		set_region(3);
		push_alloc(252);          // whole 8-block region
		push_alloc(0);            // nothing left
		push_free(1023);          // outside the region
		push_free(0);
		push_alloc(253);          // one over the region
		push_alloc(0);
		push_alloc(0);
		push_free(1);
		push_free(0);

		// random part over several region sizes and idle patterns
		for (int p = 0; p < 6; p++) begin
			set_region(regions[p]);
			for (int m = 0; m < 4; m++) begin
				send_idle_pct = send_modes[m];
				stall_pct = stall_modes[m];
				push_random(34);
				if (p == 0 && m == 0) begin
					// result side holds off while requests keep coming
					long_hold_toggle++;
				end
				if (p == 1 && m == 3) begin
					// sender waits until every grant is back
					while (pending_reqs.size() > 0 || expected_grants.size() > 0)
						@(posedge clk);
				end
				push_random(34);
			end
		end

		drain();
		if (fails == 0) begin
			$display("buddy_block_allocator_top verification clean");
		end else begin
			$display("buddy_block_allocator_top verification failed");
		end
		$finish;
	end
endmodule

/* buddy_block_allocator_top.f */
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/buddy_block_allocator_top.sv
rtl/bba_checker.sv
sim/testbench.sv
